>>> sv/ltp_pkg.sv
`default_nettype none

package ltp_pkg;

  localparam int PRIO_W      = 8;
  localparam int TICKET_W    = 9;
  localparam int RAND_W      = 32;
  localparam int DIV_CNT_W   = 5;
  localparam int TICKET_BASE = 500;
  localparam int PRIO_MAX    = 139;

  // 500 * p / 140 equals 25 * p / 7. The reciprocal 117050 / 2^15 gives the
  // exact quotient for every priority up to the clamp.
  localparam int RECIP       = 117050;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = 25;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PICK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DIV,
    S_WALK_RD,
    S_WALK_CHK,
    S_DONE
  } state_t;

  function automatic logic [TICKET_W-1:0] tickets_for(input logic [PRIO_W-1:0] prio);
    logic [PRIO_W-1:0] p;
    logic [PROD_W-1:0] prod;
    p    = (prio > PRIO_W'(PRIO_MAX)) ? PRIO_W'(PRIO_MAX) : prio;
    prod = PROD_W'(p) * PROD_W'(RECIP);
    return TICKET_W'(TICKET_BASE) - TICKET_W'(prod >> RECIP_SHIFT);
  endfunction

endpackage

`default_nettype wire

>>> sv/ltp_in_if.sv
`default_nettype none

interface ltp_in_if #(
  parameter int ID_W = 16
);
  logic                          valid;
  logic                          ready;
  ltp_pkg::func_t                func;
  logic [ID_W-1:0]               task_id;
  logic [ltp_pkg::PRIO_W-1:0]    priority_req;
  logic [ltp_pkg::RAND_W-1:0]    random_value;

  modport source (
    output valid, func, task_id, priority_req, random_value,
    input  ready
  );

  modport sink (
    input  valid, func, task_id, priority_req, random_value,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/ltp_out_if.sv
`default_nettype none

interface ltp_out_if #(
  parameter int ID_W  = 16,
  parameter int CNT_W = 5,
  parameter int TOT_W = 13
);
  logic               valid;
  logic               ready;
  ltp_pkg::status_t   status;
  logic [ID_W-1:0]    picked_id;
  logic [TOT_W-1:0]   winning_ticket;
  logic [CNT_W-1:0]   running_count;
  logic [TOT_W-1:0]   ticket_total;

  modport source (
    output valid, status, picked_id, winning_ticket, running_count, ticket_total,
    input  ready
  );

  modport sink (
    input  valid, status, picked_id, winning_ticket, running_count, ticket_total,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/lottery_task_picker_top.sv
`default_nettype none

// Lottery task picker: a table of up to TABLE_DEPTH runnable task ids in
// arrival order, each holding 500 - prio*500/140 tickets, with enqueue,
// dequeue (oldest matching id) and pick (winner = random mod total + 1, found
// by summing tickets in table order). The block takes one item at a time and
// is ready only when idle; a finished result waits in the output register
// while the next item is accepted. The table lives in a memory with one read
// and one write port, so every search, shift or walk step has a read state
// followed by a check or write state. A rejected item or a no operation goes
// straight to the done state, enqueue writes one entry, dequeue searches for
// the id and shifts the later entries down, and pick runs the bit-serial
// remainder unit, walks the entries and then loads the result. A result that is
// still waiting for the sink holds the next result back. The table needs no
// clearing after reset; entries at or beyond the count are never used.
module lottery_task_picker_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ltp_in_if.sink    in_ch,
  ltp_out_if.source out_ch
);
  import ltp_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TOT_W = $clog2(TICKET_BASE * TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0]     DEPTH_C  = CNT_W'(TABLE_DEPTH);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RAND_W - 1);

  logic [ID_BITS-1:0]  mem_id [TABLE_DEPTH];
  logic [TICKET_W-1:0] mem_tk [TABLE_DEPTH];
  logic [ID_BITS-1:0]  rd_id_r;
  logic [TICKET_W-1:0] rd_tk_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ID_BITS-1:0]  wr_id;
  logic [TICKET_W-1:0] wr_tk;

  state_t                state_r, state_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic [PRIO_W-1:0]     prio_r, prio_nxt;
  logic [RAND_W-1:0]     q_r, q_nxt;
  logic [TOT_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [TOT_W-1:0]      sum_r, sum_nxt;
  logic [TOT_W-1:0]      win_r, win_nxt;
  logic [ID_BITS-1:0]    pick_r, pick_nxt;
  status_t               status_r, status_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TOT_W-1:0]      tot_r, tot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               o_status_r, o_status_nxt;
  logic [ID_BITS-1:0]    o_pick_r, o_pick_nxt;
  logic [TOT_W-1:0]      o_win_r, o_win_nxt;
  logic [CNT_W-1:0]      o_cnt_r, o_cnt_nxt;
  logic [TOT_W-1:0]      o_tot_r, o_tot_nxt;

  logic                  in_fire;
  logic [CNT_W-1:0]      idx_inc;
  logic [TOT_W:0]        trial;
  logic [TOT_W-1:0]      rem_step;
  logic [TOT_W-1:0]      sum_step;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign idx_inc = idx_r + 1'b1;
  assign trial   = {rem_r, q_r[RAND_W-1]};
  assign rem_step = (trial >= {1'b0, tot_r}) ? TOT_W'(trial - {1'b0, tot_r})
                                              : trial[TOT_W-1:0];
  assign sum_step = sum_r + TOT_W'(rd_tk_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr] <= wr_id;
      mem_tk[wr_addr] <= wr_tk;
    end
    rd_id_r <= mem_id[rd_addr];
    rd_tk_r <= mem_tk[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    prio_r     <= prio_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    win_r      <= win_nxt;
    pick_r     <= pick_nxt;
    status_r   <= status_nxt;
    o_status_r <= o_status_nxt;
    o_pick_r   <= o_pick_nxt;
    o_win_r    <= o_win_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_tot_r    <= o_tot_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    win_nxt       = win_r;
    pick_nxt      = pick_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    tot_nxt       = tot_r;
    out_valid_nxt = out_valid_r;
    o_status_nxt  = o_status_r;
    o_pick_nxt    = o_pick_r;
    o_win_nxt     = o_win_r;
    o_cnt_nxt     = o_cnt_r;
    o_tot_nxt     = o_tot_r;
    rd_addr       = idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_id         = rd_id_r;
    wr_tk         = rd_tk_r;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          id_nxt     = in_ch.task_id;
          prio_nxt   = in_ch.priority_req;
          q_nxt      = in_ch.random_value;
          rem_nxt    = '0;
          div_cnt_nxt = '0;
          idx_nxt    = '0;
          sum_nxt    = '0;
          win_nxt    = '0;
          pick_nxt   = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (in_ch.func)
            FN_ENQ: begin
              if (cnt_r >= DEPTH_C) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_ENQ;
              end
            end
            FN_DEQ: begin
              if (cnt_r == '0) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            FN_PICK: begin
              if (cnt_r == '0 || tot_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_DIV;
              end
            end
            FN_NOP: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_ENQ: begin
        wr_en     = 1'b1;
        wr_addr   = cnt_r[IDX_W-1:0];
        wr_id     = id_r;
        wr_tk     = tickets_for(prio_r);
        cnt_nxt   = cnt_r + 1'b1;
        tot_nxt   = tot_r + TOT_W'(tickets_for(prio_r));
        state_nxt = S_DONE;
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (rd_id_r == id_r) begin
          tot_nxt   = tot_r - TOT_W'(rd_tk_r);
          state_nxt = S_SHIFT_RD;
        end else if (idx_inc >= cnt_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        rd_addr = idx_inc[IDX_W-1:0];
        if (idx_inc < cnt_r) begin
          state_nxt = S_SHIFT_WR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_SHIFT_RD;
      end
      S_DIV: begin
        rem_nxt     = rem_step;
        q_nxt       = {q_r[RAND_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          win_nxt   = rem_step + 1'b1;
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        sum_nxt  = sum_step;
        pick_nxt = rd_id_r;
        if (sum_step >= win_r || idx_inc >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_WALK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_pick_nxt    = pick_r;
          o_win_nxt     = win_r;
          o_cnt_nxt     = cnt_r;
          o_tot_nxt     = tot_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.picked_id      = o_pick_r;
  assign out_ch.winning_ticket = o_win_r;
  assign out_ch.running_count  = o_cnt_r;
  assign out_ch.ticket_total   = o_tot_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count exceeds table depth");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (tot_r == '0))
    else $error("ticket total nonzero with an empty table");

  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_CHK) |-> (win_r != '0 && win_r <= tot_r))
    else $error("winning ticket outside the ticket total");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_WR) |-> (idx_inc < cnt_r))
    else $error("table shift beyond the last entry");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished item");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ltp_pkg::*;

  localparam int DEPTH = 16;
  localparam int ID_W = 16;
  localparam int CNT_W = 5;
  localparam int TOT_W = 13;
  localparam int IDLE_PCT = 24;
  localparam int CALM_FIRST = 150;
  localparam int CALM_LAST = 250;
  localparam int RANDOM_REQUESTS = 500;

  typedef struct packed {
    func_t            func;
    logic [ID_W-1:0]  task_id;
    logic [7:0]       prio;
    logic [31:0]      rnd;
  } sched_request_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   picked_id;
    logic [TOT_W-1:0]  winning_ticket;
    logic [CNT_W-1:0]  running_count;
    logic [TOT_W-1:0]  ticket_total;
  } sched_outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  ltp_in_if #(.ID_W(ID_W)) in_ch ();
  ltp_out_if #(.ID_W(ID_W), .CNT_W(CNT_W), .TOT_W(TOT_W)) out_ch ();

  lottery_task_picker_top #(
    .TABLE_DEPTH(DEPTH),
    .ID_BITS    (ID_W)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  sched_request_t pending_requests[$];
  sched_outcome_t expected_outcomes[$];
  sched_request_t in_flight;
  sched_outcome_t oldest_outcome;
  int             live_ids[$];
  int             requests_accepted = 0;
  int             results_seen = 0;
  int             errors = 0;

  logic [ID_W-1:0] tbl_id[DEPTH];
  logic [8:0]      tbl_tickets[DEPTH];
  int              tbl_count = 0;
  int unsigned     tbl_total = 0;

  function automatic int unsigned ticket_share(logic [7:0] prio);
    int unsigned p;
    p = (prio > 8'd139) ? 139 : prio;
    return 500 - (p * 500) / 140;
  endfunction

  function automatic sched_outcome_t schedule_outcome(sched_request_t rq);
    sched_outcome_t res;
    int             pos;
    int unsigned    acc;
    int unsigned    winner;
    logic           found;
    res = '0;
    res.status = ST_OK;
    case (rq.func)
      FN_ENQ: begin
        if (tbl_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_id[tbl_count] = rq.task_id;
          tbl_tickets[tbl_count] = 9'(ticket_share(rq.prio));
          tbl_total += ticket_share(rq.prio);
          tbl_count++;
        end
      end
      FN_DEQ: begin
        pos = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (pos < 0 && tbl_id[i] == rq.task_id) pos = i;
        end
        if (pos < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          tbl_total -= tbl_tickets[pos];
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_tickets[i] = tbl_tickets[i+1];
          end
          tbl_count--;
        end
      end
      FN_PICK: begin
        if (tbl_count == 0 || tbl_total == 0) begin
          res.status = ST_EMPTY;
        end else begin
          winner = rq.rnd % tbl_total + 1;
          acc = 0;
          found = 1'b0;
          res.picked_id = tbl_id[0];
          for (int i = 0; i < tbl_count; i++) begin
            if (!found) begin
              acc += tbl_tickets[i];
              res.picked_id = tbl_id[i];
              if (acc >= winner) found = 1'b1;
            end
          end
          res.winning_ticket = TOT_W'(winner);
        end
      end
      default: begin
      end
    endcase
    res.running_count = CNT_W'(tbl_count);
    res.ticket_total = TOT_W'(tbl_total);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // The list of live ids follows the table so that most dequeues name a task that is present.
  task automatic queue_request(func_t f, int id, int prio, logic [31:0] rnd);
    sched_request_t rq;
    int             hit;
    rq.func = f;
    rq.task_id = ID_W'(id);
    rq.prio = 8'(prio);
    rq.rnd = rnd;
    pending_requests.push_back(rq);
    hit = -1;
    if (f == FN_ENQ && live_ids.size() < DEPTH) live_ids.push_back(id);
    if (f == FN_DEQ) begin
      foreach (live_ids[k]) begin
        if (hit < 0 && live_ids[k] == id) hit = k;
      end
      if (hit >= 0) live_ids.delete(hit);
    end
  endtask

  task automatic build_requests();
    int target;
    int roll;
    int id;
    int prio;
    queue_request(FN_PICK, 16'h0001, 8'd0, 32'h1234_5678);
    queue_request(FN_DEQ, 16'h0005, 8'd0, 32'h0);
    queue_request(FN_NOP, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    queue_request(FN_ENQ, 16'hFFFF, 8'd0, 32'h0);
    queue_request(FN_ENQ, 16'h0000, 8'd139, 32'h0);
    queue_request(FN_ENQ, 16'h1234, 8'd255, 32'h0);
    queue_request(FN_ENQ, 16'h1234, 8'd140, 32'h0);
    for (int k = 0; k < 12; k++) queue_request(FN_ENQ, 16'h0100 + k, k * 11, 32'h0);
    queue_request(FN_ENQ, 16'hAAAA, 8'd10, 32'h0);
    queue_request(FN_PICK, 16'h0000, 8'd0, 32'h0);
    queue_request(FN_PICK, 16'h0000, 8'd0, 32'hFFFF_FFFF);
    queue_request(FN_DEQ, 16'h1234, 8'd0, 32'h0);
    queue_request(FN_DEQ, 16'h5555, 8'd0, 32'h0);
    queue_request(FN_PICK, 16'h0000, 8'd0, 32'h5555_AAAA);
    target = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) target = $urandom_range(0, DEPTH);
      roll = $urandom_range(99);
      id = $urandom_range(0, 65535);
      prio = $urandom_range(0, 255);
      if (roll < 5) begin
        queue_request(FN_NOP, id, prio, $urandom());
      end else if (roll < 35) begin
        queue_request(FN_PICK, id, prio, $urandom());
      end else if ((live_ids.size() < target) ? ($urandom_range(9) < 8)
                                              : ($urandom_range(9) < 2)) begin
        if ($urandom_range(1) == 0) id = $urandom_range(0, 7);
        if ($urandom_range(9) != 0) prio = $urandom_range(0, 139);
        queue_request(FN_ENQ, id, prio, $urandom());
      end else begin
        if (live_ids.size() > 0 && $urandom_range(9) < 8) begin
          id = live_ids[$urandom_range(live_ids.size() - 1)];
        end
        queue_request(FN_DEQ, id, prio, $urandom());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_outcomes.push_back(schedule_outcome(in_flight));
        requests_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() > 0 &&
            ((requests_accepted >= CALM_FIRST && requests_accepted < CALM_LAST) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_flight = pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= in_flight.func;
          in_ch.task_id <= in_flight.task_id;
          in_ch.priority_req <= in_flight.prio;
          in_ch.random_value <= in_flight.rnd;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result item arrived with no request outstanding");
          errors++;
        end else begin
          oldest_outcome = expected_outcomes.pop_front();
          check_field("status", 32'(oldest_outcome.status), 32'(out_ch.status));
          check_field("picked_id", 32'(oldest_outcome.picked_id),
                      32'(out_ch.picked_id));
          check_field("winning_ticket", 32'(oldest_outcome.winning_ticket),
                      32'(out_ch.winning_ticket));
          check_field("running_count", 32'(oldest_outcome.running_count),
                      32'(out_ch.running_count));
          check_field("ticket_total", 32'(oldest_outcome.ticket_total),
                      32'(out_ch.ticket_total));
        end
        results_seen++;
      end
      out_ch.ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                      ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_NOP;
    in_ch.task_id = '0;
    in_ch.priority_req = '0;
    in_ch.random_value = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    build_requests();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_requests.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_outcomes.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[lottery_task_picker_top] OK");
    end else begin
      $display("[lottery_task_picker_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[lottery_task_picker_top] ERROR");
    $finish;
  end

endmodule

>>> lottery_task_picker_top.f
sv/ltp_pkg.sv
sv/ltp_in_if.sv
sv/ltp_out_if.sv
sv/lottery_task_picker_top.sv
tb/sv/tb.sv
